// File: hw/rtl/insertion_sorter_unit_defines.svh
// Assertion macros shared by the insertion sorter RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef INSERTION_SORTER_UNIT_DEFINES_SVH
`define INSERTION_SORTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ISU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ISU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/isu_pkg.sv
// Types shared by the insertion sorter: transaction payloads, cell slot and cell control.
// No dependencies.
package isu_pkg;

   typedef struct packed {
      logic signed [63:0] value;
      logic               batch_end;
   } isu_req_type;

   typedef struct packed {
      logic signed [63:0] sorted_value;
      logic               last;
      logic               dropped;
   } isu_rsp_type;

   typedef struct packed {
      logic               valid;
      logic signed [63:0] value;
   } isu_slot_type;

   typedef struct packed {
      logic insert;
      logic drain;
   } isu_cell_ctl_type;

endpackage

// File: hw/rtl/isu_cell.sv
// One cell of the sorting chain: holds one slot, compares against the broadcast value.
// Depends on isu_pkg.
module isu_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  isu_pkg::isu_cell_ctl_type ctl,
   input  logic signed [63:0]        new_value,
   input  isu_pkg::isu_slot_type     prev_slot,
   input  logic                      prev_take,
   input  isu_pkg::isu_slot_type     next_slot,
   output isu_pkg::isu_slot_type     slot,
   output logic                      take
);
   import isu_pkg::*;

   logic               valid_ff, valid_in;
   logic signed [63:0] value_ff, value_in;

   // New value goes before any stored value equal to it.
   assign take = !valid_ff || (new_value <= value_ff);

   // Drain and insert never coincide; with neither, hold the slot.
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctl.drain) begin
         valid_in = next_slot.valid;
         value_in = next_slot.value;
      end else if (ctl.insert && take) begin
         if (prev_take) begin
            valid_in = prev_slot.valid;
            value_in = prev_slot.value;
         end else begin
            valid_in = 1'b1;
            value_in = new_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign slot.valid = valid_ff;
   assign slot.value = value_ff;

endmodule

// File: hw/rtl/insertion_sorter_unit.sv
// Insertion sorter for signed 64-bit values, built as a chain of compare-and-shift cells.
// Depends on isu_pkg, isu_cell and insertion_sorter_unit_defines.svh.
//
// A transaction is accepted on a rising edge with start high and busy low; each value
// enters the chain in that single cycle, so values of a batch stream in at one per clock.
// Every cell compares the new value with its own entry at once, and the cells at and past
// the insertion point shift one place up. The value marked batch_end is inserted the same
// way, then busy rises and the chain drains through cell 0, one result per clock, one
// result for each entry of the batch (1 to CAPACITY); the last result carries last,
// and busy falls in that same cycle, so the next batch may start while last is shown.
// Results appear for exactly one cycle with rsp_valid high and cannot be held off: the
// receiver must take every one. A value that arrives while all CAPACITY cells are full is
// dropped, and every result of that batch then carries dropped.
`include "insertion_sorter_unit_defines.svh"

module insertion_sorter_unit #(
   parameter int CAPACITY = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  isu_pkg::isu_req_type req_item,
   output logic                 rsp_valid,
   output isu_pkg::isu_rsp_type rsp_item
);
   import isu_pkg::*;

   isu_slot_type     slot     [CAPACITY];
   logic             take     [CAPACITY];
   isu_cell_ctl_type cell_ctl;

   logic        emit_ff, emit_in;
   logic        overflow_ff, overflow_in;
   logic        rsp_valid_ff, rsp_valid_in;
   isu_rsp_type rsp_ff, rsp_in;

   logic accept;
   logic full;
   logic final_out;

   // Chain is full once its top cell holds an entry (valid bits form a prefix).
   assign full      = slot[CAPACITY-1].valid;
   assign accept    = start && !emit_ff;
   // During drain, cell 0 shows the smallest remaining entry; last when cell 1 is empty.
   assign final_out = !slot[1].valid;

   assign cell_ctl.insert = accept && !full;
   assign cell_ctl.drain  = emit_ff;

   // Build the chain: cell 0 sees an empty, non-taking neighbor below,
   // the top cell drains in an empty slot from above.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      isu_slot_type prev_slot;
      isu_slot_type next_slot;
      logic         prev_take;

      if (i == 0) begin : g_bottom
         assign prev_slot = '0;
         assign prev_take = 1'b0;
      end else begin : g_mid_lo
         assign prev_slot = slot[i-1];
         assign prev_take = take[i-1];
      end

      if (i == CAPACITY - 1) begin : g_top
         assign next_slot = '0;
      end else begin : g_mid_hi
         assign next_slot = slot[i+1];
      end

      isu_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl),
         .new_value (req_item.value),
         .prev_slot (prev_slot),
         .prev_take (prev_take),
         .next_slot (next_slot),
         .slot      (slot[i]),
         .take      (take[i])
      );
   end

   always_comb begin
      emit_in      = emit_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      if (emit_ff) begin
         // Drain one entry per cycle into the output register.
         rsp_valid_in        = 1'b1;
         rsp_in.sorted_value = slot[0].value;
         rsp_in.last         = final_out;
         rsp_in.dropped      = overflow_ff;
         if (final_out) begin
            // Batch done: stop draining and clear the sticky drop flag.
            emit_in     = 1'b0;
            overflow_in = 1'b0;
         end
      end else if (accept) begin
         // Drop the value when full and remember it for this batch.
         if (full) begin
            overflow_in = 1'b1;
         end
         if (req_item.batch_end) begin
            emit_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff      <= 1'b0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         emit_ff      <= emit_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign busy      = emit_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // A batch end always leaves at least one entry to drain.
   `ISU_ASSERT_NOW(a_drain_nonempty, clock, reset, emit_ff, slot[0].valid,
      "drain started with an empty chain")

   // A batch-end transaction starts the drain on the next cycle.
   `ISU_ASSERT_NEXT(a_end_starts_drain, clock, reset, accept && req_item.batch_end, emit_ff,
      "batch end did not start the drain")

   // Nothing follows the final result of a batch.
   `ISU_ASSERT_NEXT(a_last_closes, clock, reset, rsp_valid_ff && rsp_ff.last, !rsp_valid_ff,
      "result strobed after the final result")

   // Occupied cells form a contiguous run from cell 0.
   for (genvar j = 1; j < CAPACITY; j++) begin : g_chk
      `ISU_ASSERT_NOW(a_valid_prefix, clock, reset, slot[j].valid, slot[j-1].valid,
         "hole in the occupied cells")
   end

endmodule
